// File: design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dnte_pkg.sv
// Package with the types, constants and helper functions of the DNS name text escaper.
package dnte_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int STEP_W = 3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_FIRST  = 8'h21;
    localparam logic [7:0] CH_LAST   = 8'h7E;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        JOB_DOT,
        JOB_DOTDOT,
        JOB_PLAIN,
        JOB_PREFIX,
        JOB_DECIMAL
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] data_byte;
        logic       add_dot;
    } t_job;

    function automatic logic is_special(logic [7:0] c);
        logic s;
        case (c)
            8'h22, 8'h27, 8'h28, 8'h29, 8'h2E, 8'h3B, 8'h40, 8'h5C, 8'h60: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic t_job_kind content_kind(logic [7:0] c);
        t_job_kind k;
        if (is_special(c)) begin
            k = JOB_PREFIX;
        end else if (c >= CH_FIRST && c <= CH_LAST) begin
            k = JOB_PLAIN;
        end else begin
            k = JOB_DECIMAL;
        end
        return k;
    endfunction

    // Returns hundreds, tens and units as three 4-bit digits.
    function automatic logic [11:0] dec_digits(logic [7:0] b);
        logic [3:0]  h;
        logic [7:0]  rem8;
        logic [6:0]  r;
        logic [17:0] prod;
        logic [3:0]  t;
        logic [6:0]  tx10;
        logic [6:0]  u;
        if (b >= 8'd200) begin
            h    = 4'd2;
            rem8 = b - 8'd200;
        end else if (b >= 8'd100) begin
            h    = 4'd1;
            rem8 = b - 8'd100;
        end else begin
            h    = 4'd0;
            rem8 = b;
        end
        r    = rem8[6:0];
        prod = 18'(r) * 18'd205;
        t    = prod[14:11];
        tx10 = 7'(t) * 7'd10;
        u    = r - tx10;
        return {h, t, u[3:0]};
    endfunction

endpackage

// File: design/dns_name_text_escaper.sv
// Top level of the DNS name text escaper: front part, job queue and back part.
// The first character of an item passes through the job queue and then the back part's
// character register before it is on o_result. Throughput: one character per cycle while
// pop is held; an item gives one to five characters, or none. The back part's single
// character register sets this rate; a four-entry job queue absorbs bursts on either side.
// Reset is synchronous and active low; it clears the label state, the queue and the output.
module dns_name_text_escaper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  dnte_pkg::t_item   i_item,
    input  logic              pop,
    output logic              empty,
    output dnte_pkg::t_result o_result
);

    logic           q_full;
    logic           job_wr;
    dnte_pkg::t_job job_in;
    logic           head_valid;
    dnte_pkg::t_job head_job;
    logic           job_done;

    dnte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .full        (full),
        .o_job_valid (job_wr),
        .o_job       (job_in)
    );

    dnte_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (job_wr),
        .i_wr_job (job_in),
        .i_rd_en  (job_done),
        .o_full   (q_full),
        .o_valid  (head_valid),
        .o_head   (head_job)
    );

    dnte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_done  (job_done),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result)
    );

endmodule

// File: design/dnte_front.sv
// Front part: accepts input items, tracks label state and classifies the items that give output into jobs.
module dnte_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  dnte_pkg::t_item i_item,
    input  logic           i_q_full,
    output logic           full,
    output logic           o_job_valid,
    output dnte_pkg::t_job o_job
);

    logic [7:0] r_bytes_left;
    logic       r_label_seen;
    logic [7:0] n_bytes_left;
    logic       n_label_seen;
    logic       accept;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    always_comb begin
        n_bytes_left      = r_bytes_left;
        n_label_seen      = r_label_seen;
        o_job_valid       = 1'b0;
        o_job.kind        = dnte_pkg::JOB_DOT;
        o_job.data_byte   = i_item.data_byte;
        o_job.add_dot     = 1'b0;
        if (accept) begin
            if (i_item.op == dnte_pkg::OP_END) begin
                o_job_valid  = (r_bytes_left != 8'd0) || !r_label_seen;
                n_bytes_left = 8'd0;
                n_label_seen = 1'b0;
            end else if (r_bytes_left == 8'd0) begin
                n_label_seen = 1'b1;
                if (i_item.data_byte == 8'd0) begin
                    o_job_valid = 1'b1;
                    o_job.kind  = dnte_pkg::JOB_DOTDOT;
                end else begin
                    n_bytes_left = i_item.data_byte;
                end
            end else begin
                o_job_valid   = 1'b1;
                o_job.kind    = dnte_pkg::content_kind(i_item.data_byte);
                o_job.add_dot = (r_bytes_left == 8'd1);
                n_bytes_left  = r_bytes_left - 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 8'd0;
            r_label_seen <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_label_seen <= n_label_seen;
        end
    end

endmodule

// File: design/dnte_queue.sv
// Short job queue between the front and the back part.
module dnte_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  dnte_pkg::t_job i_wr_job,
    input  logic           i_rd_en,
    output logic           o_full,
    output logic           o_valid,
    output dnte_pkg::t_job o_head
);

    dnte_pkg::t_job                  r_mem [dnte_pkg::QDEPTH];
    logic [dnte_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [dnte_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [dnte_pkg::QCNT_W-1:0]     r_count;
    logic [dnte_pkg::QCNT_W-1:0]     n_count;

    assign o_full  = (r_count == dnte_pkg::QCNT_W'(dnte_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

// File: design/dnte_back.sv
// Back part: expands the job at the queue head into characters, one transfer per cycle while the output slot is free.
module dnte_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  dnte_pkg::t_job   i_job,
    output logic             o_job_done,
    input  logic             pop,
    output logic             empty,
    output dnte_pkg::t_result o_result
);

    logic [dnte_pkg::STEP_W-1:0] r_step;
    logic [dnte_pkg::STEP_W-1:0] n_step;
    logic                        r_out_valid;
    logic                        n_out_valid;
    dnte_pkg::t_result           r_out;
    dnte_pkg::t_result           n_out;
    logic [dnte_pkg::STEP_W-1:0] fin_step;
    logic [7:0]                  ch;
    logic [11:0]                 digits;
    logic                        slot_free;
    logic                        emit;

    assign digits    = dnte_pkg::dec_digits(i_job.data_byte);
    assign slot_free = !r_out_valid || pop;
    assign emit      = i_job_valid && slot_free;

    always_comb begin
        fin_step = '0;
        ch       = dnte_pkg::CH_DOT;
        case (i_job.kind)
            dnte_pkg::JOB_DOT: begin
                fin_step = 3'd0;
            end
            dnte_pkg::JOB_DOTDOT: begin
                fin_step = 3'd1;
            end
            dnte_pkg::JOB_PLAIN: begin
                fin_step = i_job.add_dot ? 3'd1 : 3'd0;
                if (r_step == 3'd0) begin
                    ch = i_job.data_byte;
                end
            end
            dnte_pkg::JOB_PREFIX: begin
                fin_step = i_job.add_dot ? 3'd2 : 3'd1;
                if (r_step == 3'd0) begin
                    ch = dnte_pkg::CH_BSLASH;
                end else if (r_step == 3'd1) begin
                    ch = i_job.data_byte;
                end
            end
            dnte_pkg::JOB_DECIMAL: begin
                fin_step = i_job.add_dot ? 3'd4 : 3'd3;
                case (r_step)
                    3'd0:    ch = dnte_pkg::CH_BSLASH;
                    3'd1:    ch = dnte_pkg::CH_ZERO + {4'd0, digits[11:8]};
                    3'd2:    ch = dnte_pkg::CH_ZERO + {4'd0, digits[7:4]};
                    3'd3:    ch = dnte_pkg::CH_ZERO + {4'd0, digits[3:0]};
                    default: ch = dnte_pkg::CH_DOT;
                endcase
            end
            default: begin
                fin_step = '0;
            end
        endcase
    end

    always_comb begin
        o_job_done     = emit && (r_step == fin_step);
        n_out.char_out = ch;
        n_out.last     = (r_step == fin_step);
        n_step         = r_step;
        n_out_valid    = r_out_valid && !pop;
        if (emit) begin
            n_out_valid = 1'b1;
            n_step      = o_job_done ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

// File: design/dnte_checker.sv
// Port-level assertion checker for the DNS name text escaper, with its bind statement.
`include "assert_macros.svh"

module dnte_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              pop,
    input logic              empty,
    input dnte_pkg::t_result o_result
);

    `ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n) |-> empty, "output not empty after reset")
    `ASSERT_CLK(a_hold_when_stalled, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_result)), "result changed while stalled")
    `ASSERT_CLK(a_no_gap_in_item, i_clk, i_rst_n, (!empty && pop && !o_result.last) |=> !empty, "gap inside the characters of one item")
    `ASSERT_CLK(a_result_printable, i_clk, i_rst_n, !empty |-> (o_result.char_out >= dnte_pkg::CH_FIRST && o_result.char_out <= dnte_pkg::CH_LAST), "result character not printable")

endmodule

bind dns_name_text_escaper dnte_checker u_dnte_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
